### rtl/fbjd_pkg.sv
package fbjd_pkg;

   localparam int unsigned ValW  = 32;
   localparam int unsigned MassW = 31;
   localparam int unsigned OutW  = 31;
   localparam int unsigned AccW  = 70;
   localparam int unsigned HalfW = AccW / 2;
   localparam int unsigned NumW  = 104;
   localparam int unsigned DivW  = 64;
   localparam int unsigned CntW  = $clog2(NumW + 1);
   localparam int unsigned QW    = 33;
   localparam int unsigned SqW   = 66;
   localparam int unsigned RootW = 33;

   localparam logic [ValW-1:0] KInvSqrt2  = 32'd759250125;
   localparam logic [ValW-1:0] KSqrt2     = 32'd1518500250;
   localparam logic [ValW-1:0] KSqrt23    = 32'd876706528;
   localparam logic [ValW-1:0] KSqrt6Half = 32'd1315059792;
   localparam logic [ValW-1:0] KSqrt34    = 32'd929887697;
   localparam logic [ValW-1:0] KSqrt43    = 32'd1239850262;

   localparam logic [QW-1:0]   SatComp = 33'h080000000;
   localparam logic [OutW-1:0] OutMax  = 31'h7fffffff;

   localparam logic [1:0] SlotLast = 2'd3;

   // integer square root, 33 result bits from a 66 bit radicand, two bits a step
   function automatic logic [RootW-1:0] isqrt_step_root(
      input logic [RootW-1:0] root,
      input logic [RootW+1:0] rem_hi,
      input logic [1:0]       pair
   );
      logic [RootW+1:0] trial;
      logic [RootW+1:0] r2;
      begin
         r2    = {rem_hi[RootW-1:0], pair};
         trial = {root, 2'b01};
         isqrt_step_root = (r2 >= trial) ? {root[RootW-2:0], 1'b1} : {root[RootW-2:0], 1'b0};
      end
   endfunction

   typedef struct packed {
      logic [ValW-1:0]  pos_x;
      logic [ValW-1:0]  pos_y;
      logic [ValW-1:0]  pos_z;
      logic [ValW-1:0]  mom_x;
      logic [ValW-1:0]  mom_y;
      logic [ValW-1:0]  mom_z;
      logic [MassW-1:0] rest_mass;
      logic [1:0]       slot;
   } req_type;

   typedef struct packed {
      logic [OutW-1:0] pair_distance;
      logic [OutW-1:0] pair_momentum;
      logic [OutW-1:0] triple_distance;
      logic [OutW-1:0] triple_momentum;
      logic [OutW-1:0] quad_distance;
      logic [OutW-1:0] quad_momentum;
      logic            divide_fault;
   } rsp_type;

   typedef struct packed {
      logic            start;
      logic [NumW-1:0] num;
      logic [DivW-1:0] div;
   } div_cmd_type;

   typedef struct packed {
      logic          done;
      logic [QW-1:0] quot;
   } div_rsp_type;

endpackage

### rtl/fbjd_if.sv
interface fbjd_req_if;
   import fbjd_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface fbjd_rsp_if;
   import fbjd_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/four_body_jacobi_distances.sv
// Slots 0..2 are stored in the cycle they are accepted; a slot 3 word starts the computation.
// A slot 3 word computes 18 components (6 kinds by 3 axes), each as 1 to 3 multiply-accumulate
// terms, scaling by the constant in two halves, a divider start and the divide; then six 33 bit
// square roots of three squares each and the output step; straight to output if masses 0 and 1
// sum to zero. One word in flight: no request is taken until the result is out; a held one blocks.
// Synchronous active-high reset clears control; the particle store holds stale data until written.
module four_body_jacobi_distances (
   input logic      clock,
   input logic      reset,
   fbjd_req_if.sink req,
   fbjd_rsp_if.source rsp
);
   import fbjd_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_TERM  = 8'b00000010,
      ST_MUL   = 8'b00000100,
      ST_DIV   = 8'b00001000,
      ST_WAITD = 8'b00010000,
      ST_SQ    = 8'b00100000,
      ST_ROOT  = 8'b01000000,
      ST_OUT   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [ValW-1:0] pos_ff [4][3];
   logic signed [ValW-1:0] mom_ff [4][3];
   logic [MassW-1:0]       mass_ff [4];

   logic [2:0]  comp_ff, comp_in;   // component kind 0..5
   logic [1:0]  ax_ff, ax_in;
   logic [1:0]  term_ff, term_in;
   logic [AccW-1:0] pos_acc_ff, pos_acc_in, neg_acc_ff, neg_acc_in;
   logic [NumW-1:0] num_ff, num_in;
   logic            num_hi_ff, num_hi_in;
   logic [QW-1:0]   c_ff [6][3];
   logic [SqW-1:0]  sq_ff, sq_in;
   logic [1:0]      sqi_ff, sqi_in;
   logic [RootW-1:0] root_ff, root_in;
   logic [RootW+1:0] rem_ff, rem_in;
   logic [5:0]       rcnt_ff, rcnt_in;
   logic [OutW-1:0]  mag_ff [6];
   logic             fault_ff;
   logic             rsp_valid_ff;

   div_cmd_type dcmd;
   div_rsp_type drsp;

   logic [ValW+1:0] tval;
   logic [ValW:0]   tw;
   logic            tlast;
   logic [ValW+1:0] tmag;
   logic [AccW-1:0] prod;
   logic [MassW+1:0] d2, d3, d4;
   logic [AccW-1:0] acc_mag;
   logic [ValW-1:0] kconst;
   logic [MassW+1:0] dsel;
   logic [HalfW-1:0] mul_a;
   logic [HalfW+ValW-1:0] mul_p;
   logic [QW-1:0]   csq;
   logic [SqW-1:0]  csq2;
   logic [RootW+1:0] r2, trial;

   fbjd_divider u_div (.clock(clock), .reset(reset), .cmd(dcmd), .rsp(drsp));

   assign d2 = {2'b0, mass_ff[0]} + {2'b0, mass_ff[1]};
   assign d3 = d2 + {2'b0, mass_ff[2]};
   assign d4 = d3 + {2'b0, mass_ff[3]};

   // term selection: weight and signed value for (comp, term, axis)
   always_comb begin
      tw    = '0;
      tval  = '0;
      tlast = 1'b1;
      case (comp_ff)
         3'd0: begin
            tw   = {{ValW{1'b0}}, 1'b1};
            tval = {{2{pos_ff[0][ax_ff][ValW-1]}}, pos_ff[0][ax_ff]}
                 - {{2{pos_ff[1][ax_ff][ValW-1]}}, pos_ff[1][ax_ff]};
         end
         3'd1: begin
            tlast = term_ff == 2'd1;
            if (term_ff == 2'd0) begin
               tw   = {2'b0, mass_ff[1]};
               tval = {{2{mom_ff[0][ax_ff][ValW-1]}}, mom_ff[0][ax_ff]};
            end else begin
               tw   = {2'b0, mass_ff[0]};
               tval = -{{2{mom_ff[1][ax_ff][ValW-1]}}, mom_ff[1][ax_ff]};
            end
         end
         3'd2, 3'd4: begin
            tlast = (comp_ff == 3'd2) ? (term_ff == 2'd1) : (term_ff == 2'd2);
            tw    = {2'b0, mass_ff[term_ff]};
            if (comp_ff == 3'd2) begin
               tval = {{2{pos_ff[term_ff][ax_ff][ValW-1]}}, pos_ff[term_ff][ax_ff]}
                    - {{2{pos_ff[2][ax_ff][ValW-1]}}, pos_ff[2][ax_ff]};
            end else begin
               tval = {{2{pos_ff[term_ff][ax_ff][ValW-1]}}, pos_ff[term_ff][ax_ff]}
                    - {{2{pos_ff[3][ax_ff][ValW-1]}}, pos_ff[3][ax_ff]};
            end
         end
         3'd3: begin
            tlast = term_ff == 2'd1;
            if (term_ff == 2'd0) begin
               tw   = {2'b0, mass_ff[2]};
               tval = {{2{mom_ff[0][ax_ff][ValW-1]}}, mom_ff[0][ax_ff]}
                    + {{2{mom_ff[1][ax_ff][ValW-1]}}, mom_ff[1][ax_ff]};
            end else begin
               tw   = d2;
               tval = -{{2{mom_ff[2][ax_ff][ValW-1]}}, mom_ff[2][ax_ff]};
            end
         end
         3'd5: begin
            tlast = term_ff == 2'd1;
            if (term_ff == 2'd0) begin
               tw   = {2'b0, mass_ff[3]};
               tval = {{2{mom_ff[0][ax_ff][ValW-1]}}, mom_ff[0][ax_ff]}
                    + {{2{mom_ff[1][ax_ff][ValW-1]}}, mom_ff[1][ax_ff]}
                    + {{2{mom_ff[2][ax_ff][ValW-1]}}, mom_ff[2][ax_ff]};
            end else begin
               tw   = d3;
               tval = -{{2{mom_ff[3][ax_ff][ValW-1]}}, mom_ff[3][ax_ff]};
            end
         end
         default: begin
            tw = '0;
         end
      endcase
      tmag = tval[ValW+1] ? -tval : tval;
      prod = AccW'(tw) * AccW'(tmag);
      acc_mag = (pos_acc_ff >= neg_acc_ff) ? pos_acc_ff - neg_acc_ff
                                           : neg_acc_ff - pos_acc_ff;
      case (comp_ff)
         3'd0:    begin kconst = KInvSqrt2;  dsel = '0; end
         3'd1:    begin kconst = KSqrt2;     dsel = d2; end
         3'd2:    begin kconst = KSqrt23;    dsel = d2; end
         3'd3:    begin kconst = KSqrt6Half; dsel = d3; end
         3'd4:    begin kconst = KSqrt34;    dsel = d3; end
         default: begin kconst = KSqrt43;    dsel = d4; end
      endcase
      dcmd.start = state_ff == ST_DIV;
      dcmd.div   = (comp_ff == 3'd0) ? (DivW'(1) << 30)
                                     : (DivW'(dsel) << 30);
      // scale by the constant one half of the accumulator at a time
      mul_a      = num_hi_ff ? acc_mag[AccW-1:HalfW] : acc_mag[HalfW-1:0];
      mul_p      = (HalfW+ValW)'(mul_a) * (HalfW+ValW)'(kconst);
      dcmd.num   = num_ff;
      csq  = c_ff[comp_ff][sqi_ff];
      csq2 = SqW'(csq) * SqW'(csq);
      r2    = {rem_ff[RootW-1:0], sq_ff[SqW-1 -: 2]};
      trial = {root_ff, 2'b01};
   end

   always_comb begin
      state_in   = state_ff;
      comp_in    = comp_ff;
      ax_in      = ax_ff;
      term_in    = term_ff;
      pos_acc_in = pos_acc_ff;
      neg_acc_in = neg_acc_ff;
      num_in     = num_ff;
      num_hi_in  = num_hi_ff;
      sq_in      = sq_ff;
      sqi_in     = sqi_ff;
      root_in    = root_ff;
      rem_in     = rem_ff;
      rcnt_in    = rcnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.data.slot == SlotLast) begin
               comp_in    = '0;
               ax_in      = '0;
               term_in    = '0;
               pos_acc_in = '0;
               neg_acc_in = '0;
               state_in   = ST_TERM;
            end
         end
         ST_TERM: begin
            if (d2 == '0) begin
               state_in = ST_OUT;
            end else begin
               if (tval[ValW+1]) neg_acc_in = neg_acc_ff + prod;
               else              pos_acc_in = pos_acc_ff + prod;
               term_in = term_ff + 1'b1;
               if (tlast) begin
                  num_hi_in = 1'b0;
                  state_in  = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (!num_hi_ff) begin
               num_in    = NumW'(mul_p) + NumW'(dcmd.div >> 1);
               num_hi_in = 1'b1;
            end else begin
               num_in   = num_ff + (NumW'(mul_p) << HalfW);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            state_in = ST_WAITD;
         end
         ST_WAITD: begin
            if (drsp.done) begin
               pos_acc_in = '0;
               neg_acc_in = '0;
               term_in    = '0;
               if (ax_ff == 2'd2) begin
                  ax_in = '0;
                  if (comp_ff == 3'd5) begin
                     comp_in  = '0;
                     sqi_in   = '0;
                     sq_in    = '0;
                     state_in = ST_SQ;
                  end else begin
                     comp_in  = comp_ff + 1'b1;
                     state_in = ST_TERM;
                  end
               end else begin
                  ax_in    = ax_ff + 1'b1;
                  state_in = ST_TERM;
               end
            end
         end
         ST_SQ: begin
            sq_in  = sq_ff + csq2;
            sqi_in = sqi_ff + 1'b1;
            if (sqi_ff == 2'd2) begin
               root_in  = '0;
               rem_in   = '0;
               rcnt_in  = 6'(RootW);
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            sq_in   = {sq_ff[SqW-3:0], 2'b00};
            root_in = isqrt_step_root(root_ff, rem_ff, sq_ff[SqW-1 -: 2]);
            rem_in  = (r2 >= trial) ? r2 - trial : r2;
            rcnt_in = rcnt_ff - 1'b1;
            if (rcnt_ff == 6'd1) begin
               sqi_in = '0;
               sq_in  = '0;
               if (comp_ff == 3'd5) begin
                  state_in = ST_OUT;
               end else begin
                  comp_in  = comp_ff + 1'b1;
                  state_in = ST_SQ;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req.ready = state_ff == ST_IDLE;

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         for (int a = 0; a < 3; a++) begin
            pos_ff[req.data.slot][a] <= (a == 0) ? req.data.pos_x
                                      : (a == 1) ? req.data.pos_y : req.data.pos_z;
            mom_ff[req.data.slot][a] <= (a == 0) ? req.data.mom_x
                                      : (a == 1) ? req.data.mom_y : req.data.mom_z;
         end
         mass_ff[req.data.slot] <= req.data.rest_mass;
      end
      if (state_ff == ST_WAITD && drsp.done) c_ff[comp_ff][ax_ff] <= drsp.quot;
      if (state_ff == ST_ROOT && rcnt_ff == 6'd1) begin
         mag_ff[comp_ff] <= (root_in > RootW'(OutMax)) ? OutMax : root_in[OutW-1:0];
      end
      comp_ff    <= comp_in;
      ax_ff      <= ax_in;
      term_ff    <= term_in;
      pos_acc_ff <= pos_acc_in;
      neg_acc_ff <= neg_acc_in;
      num_ff     <= num_in;
      num_hi_ff  <= num_hi_in;
      sq_ff      <= sq_in;
      sqi_ff     <= sqi_in;
      root_ff    <= root_in;
      rem_ff     <= rem_in;
      rcnt_ff    <= rcnt_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fault_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_TERM && d2 == '0) fault_ff <= 1'b1;
         if (state_ff == ST_IDLE && state_in == ST_TERM) fault_ff <= 1'b0;
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp.ready)) begin
         rsp.data.divide_fault    <= fault_ff;
         rsp.data.pair_distance   <= fault_ff ? '0 : mag_ff[0];
         rsp.data.pair_momentum   <= fault_ff ? '0 : mag_ff[1];
         rsp.data.triple_distance <= fault_ff ? '0 : mag_ff[2];
         rsp.data.triple_momentum <= fault_ff ? '0 : mag_ff[3];
         rsp.data.quad_distance   <= fault_ff ? '0 : mag_ff[4];
         rsp.data.quad_momentum   <= fault_ff ? '0 : mag_ff[5];
      end
   end

   assign rsp.valid = rsp_valid_ff;

endmodule

### rtl/fbjd_divider.sv
// Restoring divider: one quotient bit a cycle, quotient held at 2^31
module fbjd_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  fbjd_pkg::div_cmd_type cmd,
   output fbjd_pkg::div_rsp_type rsp
);
   import fbjd_pkg::*;

   logic [NumW-1:0] num_ff, num_in;
   logic [DivW:0]   rem_ff, rem_in;
   logic [DivW-1:0] div_ff, div_in;
   logic [QW-1:0]   q_ff, q_in;
   logic            sat_ff, sat_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DivW:0]   shifted;
   logic            take;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DivW-1:0], num_ff[NumW-1]};
      take    = shifted >= {1'b0, div_ff};
      if (cmd.start) begin
         num_in  = cmd.num;
         div_in  = cmd.div;
         rem_in  = '0;
         q_in    = '0;
         sat_in  = 1'b0;
         cnt_in  = CntW'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NumW-2:0], 1'b0};
         rem_in = take ? shifted - {1'b0, div_ff} : shifted;
         if (take && (cnt_ff > CntW'(QW))) begin
            sat_in = 1'b1;
         end
         q_in   = {q_ff[QW-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = (sat_ff || q_ff >= SatComp) ? SatComp : q_ff;

endmodule

### rtl/fbjd_checker.sv
module fbjd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic [1:0] req_slot,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_fault,
   input logic [30:0] rsp_pd
);
   import fbjd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_pd == '0) else $error("fault with data");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_slot == SlotLast |=> !req_ready)
      else $error("ready while computing");

   a_no_rsp_store: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && req_ready && req_slot != SlotLast |=> !rsp_valid)
      else $error("result from stored word");

endmodule

bind four_body_jacobi_distances fbjd_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_slot(req.data.slot),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_fault(rsp.data.divide_fault), .rsp_pd(rsp.data.pair_distance)
);
